### hw/rtl/cie_pkg.sv
// shared types and constants for the container image extractor
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cie_pkg;

    // stream layout
    localparam int unsigned PrefixLen   = 9;
    localparam int unsigned HeaderLen   = 20;
    localparam int unsigned BlkHdrLen   = 9;
    localparam int unsigned DurationLen = 8;
    localparam int unsigned MagicLen    = 4;

    localparam int unsigned CountW  = 5;   // holds positions up to HeaderLen - 1
    localparam int unsigned LengthW = 64;

    localparam logic [7:0] TypeSkip  = 8'h02;
    localparam logic [7:0] TypeImage = 8'h03;

    // result codes
    typedef enum logic [2:0] {
        ST_PAYLOAD   = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_TOO_SHORT = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // parser phases, one-hot
    typedef enum logic [6:0] {
        PH_PREFIX  = 7'b0000001,
        PH_HEADER  = 7'b0000010,
        PH_BLKHDR  = 7'b0000100,
        PH_SKIP    = 7'b0001000,
        PH_DUR     = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    // one result item from the parser to the output stage
    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [7:0] payload;
        logic       last;
    } result_t;

    // expected magic bytes "CAFF"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h43;
            2'd1:    val = 8'h41;
            2'd2:    val = 8'h46;
            2'd3:    val = 8'h46;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/container_image_extractor_unit.sv
// an accepted byte waits in the input register; its result, if it makes one, is captured in the result register
// throughput: one byte per cycle while the master side does not stall; input register, parser logic, result register
// a stalled master side holds the result register and then the input register
// reset (rst_n, async, active low) clears the valid flags and puts the parser at the prefix
// top level of the container image extractor
// depends on cie_pkg, cie_parser, cie_out_stage
`timescale 1ns / 1ps
`default_nettype none

module container_image_extractor_unit
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [7:0]      s_axis_tdata,   // data_byte
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // payload_byte
    output logic                 m_axis_tlast,   // last
    output logic [2:0]           m_axis_tuser    // status
);

    logic                 in_valid_reg;
    logic [7:0]           in_data_reg;
    logic                 can_load;
    logic                 step;
    cie_pkg::result_t     result;

    // the registered byte moves on when the result register can take it
    assign step          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    cie_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .result    (result)
    );

    cie_out_stage u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step && result.valid),
        .result        (result),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

### hw/rtl/cie_parser.sv
// container parser: phase state and per-byte decode
// depends on cie_pkg
`timescale 1ns / 1ps
`default_nettype none

module cie_parser
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,       // one byte consumed this cycle
    input  wire logic [7:0]      data_byte,
    output cie_pkg::result_t     result
);

    cie_pkg::phase_t                      phase_reg, phase_next;
    logic [cie_pkg::CountW-1:0]           count_reg, count_next;
    logic [7:0]                           kind_reg, kind_next;
    logic [cie_pkg::LengthW-1:0]          length_reg, length_next;
    logic                                 magic_ok_reg, magic_ok_next;

    logic [cie_pkg::LengthW-1:0]          length_asm;
    logic [cie_pkg::LengthW-1:0]          length_dec;
    logic [2:0]                           lane;
    logic                                 count_last;

    // size assembly: little-endian lane write of the current byte
    always_comb
    begin
        lane       = 3'(count_reg - 1'b1);
        length_asm = length_reg;
        if (count_reg == '0)
        begin
            length_asm = '0;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (lane == 3'(i))
                begin
                    length_asm[8*i +: 8] = data_byte;
                end
            end
        end
    end

    assign length_dec = length_reg - 1'b1;

    // next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        length_next    = length_reg;
        magic_ok_next  = magic_ok_reg;
        count_last     = 1'b0;
        result.valid   = 1'b0;
        result.status  = cie_pkg::ST_PAYLOAD;
        result.payload = 8'h00;
        result.last    = 1'b0;

        case (phase_reg)
            cie_pkg::PH_PREFIX:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == cie_pkg::CountW'(cie_pkg::PrefixLen - 1))
                begin
                    phase_next = cie_pkg::PH_HEADER;
                    count_next = '0;
                end
            end

            cie_pkg::PH_HEADER:
            begin
                if (count_reg < cie_pkg::CountW'(cie_pkg::MagicLen) &&
                    data_byte != cie_pkg::magic_byte(count_reg[1:0]))
                begin
                    magic_ok_next = 1'b0;
                end
                count_next = count_reg + 1'b1;
                if (count_reg == cie_pkg::CountW'(cie_pkg::HeaderLen - 1))
                begin
                    count_next = '0;
                    if (!magic_ok_reg)
                    begin
                        phase_next    = cie_pkg::PH_DONE;
                        result.valid  = 1'b1;
                        result.status = cie_pkg::ST_BAD_MAGIC;
                        result.last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = cie_pkg::PH_BLKHDR;
                    end
                end
            end

            cie_pkg::PH_BLKHDR:
            begin
                if (count_reg == '0)
                begin
                    kind_next = data_byte;
                end
                length_next = length_asm;
                count_next  = count_reg + 1'b1;
                count_last  = (count_reg == cie_pkg::CountW'(cie_pkg::BlkHdrLen - 1));
                if (count_last)
                begin
                    count_next = '0;
                    if (kind_reg == cie_pkg::TypeSkip)
                    begin
                        // a zero-size skip block goes straight to the next header
                        if (length_asm != '0)
                        begin
                            phase_next = cie_pkg::PH_SKIP;
                        end
                    end
                    else if (kind_reg == cie_pkg::TypeImage)
                    begin
                        if (length_asm < cie_pkg::LengthW'(cie_pkg::DurationLen))
                        begin
                            phase_next    = cie_pkg::PH_DONE;
                            result.valid  = 1'b1;
                            result.status = cie_pkg::ST_TOO_SHORT;
                            result.last   = 1'b1;
                        end
                        else
                        begin
                            length_next = length_asm - cie_pkg::LengthW'(cie_pkg::DurationLen);
                            phase_next  = cie_pkg::PH_DUR;
                        end
                    end
                    else
                    begin
                        phase_next    = cie_pkg::PH_DONE;
                        result.valid  = 1'b1;
                        result.status = cie_pkg::ST_BAD_TYPE;
                        result.last   = 1'b1;
                    end
                end
            end

            cie_pkg::PH_SKIP:
            begin
                length_next = length_dec;
                if (length_dec == '0)
                begin
                    phase_next = cie_pkg::PH_BLKHDR;
                    count_next = '0;
                end
            end

            cie_pkg::PH_DUR:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == cie_pkg::CountW'(cie_pkg::DurationLen - 1))
                begin
                    count_next = '0;
                    if (length_reg == '0)
                    begin
                        phase_next    = cie_pkg::PH_DONE;
                        result.valid  = 1'b1;
                        result.status = cie_pkg::ST_EMPTY;
                        result.last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = cie_pkg::PH_PAYLOAD;
                    end
                end
            end

            cie_pkg::PH_PAYLOAD:
            begin
                length_next    = length_dec;
                result.valid   = 1'b1;
                result.status  = cie_pkg::ST_PAYLOAD;
                result.payload = data_byte;
                result.last    = (length_dec == '0);
                if (length_dec == '0)
                begin
                    phase_next = cie_pkg::PH_DONE;
                end
            end

            default:
            begin
                phase_next = cie_pkg::PH_DONE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= cie_pkg::PH_PREFIX;
            count_reg    <= '0;
            kind_reg     <= '0;
            length_reg   <= '0;
            magic_ok_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            kind_reg     <= kind_next;
            length_reg   <= length_next;
            magic_ok_reg <= magic_ok_next;
        end
    end

    // once finished the parser never leaves that phase
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == cie_pkg::PH_DONE |=> phase_reg == cie_pkg::PH_DONE)
        else $error("parser left finished phase");

    // every error or empty report closes the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != cie_pkg::ST_PAYLOAD |-> result.last)
        else $error("terminal status without last flag");

    // a last-flagged result, once consumed, is always followed by the finished phase
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.valid && result.last |=> phase_reg == cie_pkg::PH_DONE)
        else $error("result flagged last but parser still active");

endmodule

`default_nettype wire

### hw/rtl/cie_out_stage.sv
// result register feeding the master stream side
// depends on cie_pkg
`timescale 1ns / 1ps
`default_nettype none

module cie_out_stage
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,       // capture result this cycle
    input  wire cie_pkg::result_t result,
    output logic                 can_load,   // register free or draining
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // payload_byte
    output logic                 m_axis_tlast,   // last
    output logic [2:0]           m_axis_tuser    // status
);

    logic                 valid_reg;
    logic [7:0]           payload_reg;
    logic                 last_reg;
    cie_pkg::status_t     status_reg;

    assign can_load = !valid_reg || m_axis_tready;

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload fields
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            payload_reg <= result.payload;
            last_reg    <= result.last;
            status_reg  <= result.status;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = payload_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = status_reg;

    // a new result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || m_axis_tready))
        else $error("result register overwritten while stalled");

    // only valid results are captured
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> result.valid)
        else $error("empty result captured");

endmodule

`default_nettype wire

### verif/tb_container_image_extractor_unit.sv
// self-checking testbench for container_image_extractor_unit: drives one container stream
// through the byte port and checks every result against a parser model kept in this file
// depends on cie_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_container_image_extractor_unit;

    // "CAFF", first byte in the lowest bits
    localparam logic [31:0] MagicWord = {8'h46, 8'h46, 8'h41, 8'h43};
    localparam int unsigned HoldoffCycles = 80;
    localparam int unsigned ModeBand = 150;
    localparam int unsigned TotalItems = 1750;

    typedef struct {
        cie_pkg::status_t status;
        logic [7:0]       payload;
        logic             last;
    } extract_out_t;

    typedef struct {
        logic [7:0] data;
        bit         drain;
    } byte_slot_t;

    // how the container ends
    typedef enum int {
        CLOSE_BAD_MAGIC,
        CLOSE_BAD_TYPE,
        CLOSE_TOO_SHORT,
        CLOSE_EMPTY,
        CLOSE_PAYLOAD
    } close_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SENDER,
        MODE_RECEIVER,
        MODE_BOTH
    } idle_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;      // data_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;              // payload_byte
    logic       m_axis_tlast;              // last
    logic [2:0] m_axis_tuser;              // status

    byte_slot_t   stream_bytes[$];
    extract_out_t due_results[$];

    // parser state mirrored from the block
    cie_pkg::phase_t ph = cie_pkg::PH_PREFIX;
    logic [63:0] pos = '0;
    logic [7:0]  kind = '0;
    logic [63:0] remaining = '0;
    logic        magic_good = 1'b1;

    int unsigned bytes_taken = 0;
    int unsigned results_due = 0;
    int unsigned results_seen = 0;
    int unsigned fail_cnt = 0;
    int unsigned holdoff_left = 0;
    bit          holdoff_used = 1'b0;
    idle_mode_t  idle_mode = MODE_NONE;

    container_image_extractor_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
    end

    // advance the parser model by one accepted byte
    task automatic parse_byte(input logic [7:0] b);
        extract_out_t r;
        bit           emit;
        emit = 1'b0;
        r.status = cie_pkg::ST_PAYLOAD;
        r.payload = 8'h00;
        r.last = 1'b1;
        case (ph)
            cie_pkg::PH_PREFIX:
            begin
                pos++;
                if (pos >= cie_pkg::PrefixLen)
                begin
                    ph = cie_pkg::PH_HEADER;
                    pos = '0;
                end
            end
            cie_pkg::PH_HEADER:
            begin
                if (pos < cie_pkg::MagicLen && b != MagicWord[8 * pos[1:0] +: 8])
                    magic_good = 1'b0;
                pos++;
                if (pos >= cie_pkg::HeaderLen)
                begin
                    pos = '0;
                    if (!magic_good)
                    begin
                        ph = cie_pkg::PH_DONE;
                        emit = 1'b1;
                        r.status = cie_pkg::ST_BAD_MAGIC;
                    end
                    else
                        ph = cie_pkg::PH_BLKHDR;
                end
            end
            cie_pkg::PH_BLKHDR:
            begin
                if (pos == 0)
                begin
                    kind = b;
                    remaining = '0;
                end
                else
                    remaining |= {56'd0, b} << (8 * (pos - 1));
                pos++;
                if (pos >= cie_pkg::BlkHdrLen)
                begin
                    pos = '0;
                    if (kind == cie_pkg::TypeSkip)
                    begin
                        if (remaining != 0)
                            ph = cie_pkg::PH_SKIP;
                    end
                    else if (kind == cie_pkg::TypeImage)
                    begin
                        if (remaining < cie_pkg::DurationLen)
                        begin
                            ph = cie_pkg::PH_DONE;
                            emit = 1'b1;
                            r.status = cie_pkg::ST_TOO_SHORT;
                        end
                        else
                        begin
                            remaining -= cie_pkg::DurationLen;
                            ph = cie_pkg::PH_DUR;
                        end
                    end
                    else
                    begin
                        ph = cie_pkg::PH_DONE;
                        emit = 1'b1;
                        r.status = cie_pkg::ST_BAD_TYPE;
                    end
                end
            end
            cie_pkg::PH_SKIP:
            begin
                remaining--;
                if (remaining == 0)
                begin
                    ph = cie_pkg::PH_BLKHDR;
                    pos = '0;
                end
            end
            cie_pkg::PH_DUR:
            begin
                pos++;
                if (pos >= cie_pkg::DurationLen)
                begin
                    pos = '0;
                    if (remaining == 0)
                    begin
                        ph = cie_pkg::PH_DONE;
                        emit = 1'b1;
                        r.status = cie_pkg::ST_EMPTY;
                    end
                    else
                        ph = cie_pkg::PH_PAYLOAD;
                end
            end
            cie_pkg::PH_PAYLOAD:
            begin
                remaining--;
                pos++;
                emit = 1'b1;
                r.payload = b;
                r.last = (remaining == 0);
                if (remaining == 0)
                    ph = cie_pkg::PH_DONE;
            end
            default:
                ph = cie_pkg::PH_DONE;
        endcase
        if (emit)
        begin
            due_results.push_back(r);
            results_due++;
        end
    endtask

    task automatic queue_byte(input logic [7:0] d, input bit drain = 1'b0);
        byte_slot_t s;
        s.data = d;
        s.drain = drain;
        stream_bytes.push_back(s);
    endtask

    // type byte followed by a little-endian 64-bit size
    task automatic queue_block_header(input logic [7:0] t, input logic [63:0] size);
        queue_byte(t);
        for (int i = 0; i < 8; i++)
            queue_byte(size[8 * i +: 8]);
    endtask

    // sender: pops the next byte when the previous one is taken
    always @(posedge clk or negedge rst_n)
    begin : drive
        byte_slot_t nxt;
        bit         gap;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_byte(s_axis_tdata);
                bytes_taken++;
                idle_mode <= idle_mode_t'((bytes_taken / ModeBand) % 4);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                case (idle_mode)
                    MODE_SENDER: gap = ($urandom_range(0, 99) < 59);
                    MODE_BOTH:   gap = ($urandom_range(0, 99) < 22);
                    default:     gap = 1'b0;
                endcase
                // a drain item waits for every outstanding result
                if (stream_bytes.size() != 0 && !gap &&
                    !(stream_bytes[0].drain && results_due != results_seen))
                begin
                    nxt = stream_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt.data;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off at the first result so the pipeline backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_used <= 1'b0;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (!holdoff_used && m_axis_tvalid)
        begin
            holdoff_left <= HoldoffCycles;
            holdoff_used <= 1'b1;
        end
    end

    // receiver: checks each taken result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : watch
        extract_out_t want;
        bit           stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (due_results.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result at %0t: status %0d byte %02h last %b",
                                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_axis_tuser !== want.status || m_axis_tdata !== want.payload ||
                        m_axis_tlast !== want.last)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch at %0t: expected %0d/%02h/%b got %0d/%02h/%b",
                                     $time, want.status, want.payload, want.last,
                                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            case (idle_mode)
                MODE_RECEIVER: stall = ($urandom_range(0, 99) < 59);
                MODE_BOTH:     stall = ($urandom_range(0, 99) < 22);
                default:       stall = 1'b0;
            endcase
            m_axis_tready <= (holdoff_left == 0) && !stall;
        end
    end

    // stimulus and end of run
    initial
    begin
        close_t      closing;
        int unsigned skip_total;
        int unsigned skip_target;
        int unsigned size;
        int unsigned bad_idx;
        int unsigned pad;
        logic [7:0]  t;
        logic [63:0] size_word;

        closing = close_t'($urandom_range(0, 9) < 4 ? $urandom_range(0, 3) : CLOSE_PAYLOAD);

        // block prefix with extreme patterns
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h55);
        queue_byte(8'hAA);
        queue_byte(8'h01);
        queue_byte(8'h80);
        queue_byte(8'h7F);
        queue_byte(8'hFE);
        queue_byte(8'h00);

        // header: magic, possibly corrupted in one byte
        bad_idx = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
        begin
            t = MagicWord[8 * i +: 8];
            if (closing == CLOSE_BAD_MAGIC && i == bad_idx)
                t ^= 8'($urandom_range(1, 255));
            queue_byte(t);
        end
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(8'hAA);
        queue_byte(8'h55);
        for (int i = 0; i < 12; i++)
            queue_byte(8'($urandom));

        if (closing != CLOSE_BAD_MAGIC)
        begin
            // zero-size skip block, then a one-byte skip block
            queue_block_header(cie_pkg::TypeSkip, 64'd0);
            queue_block_header(cie_pkg::TypeSkip, 64'd1);
            queue_byte(8'hFF);

            // random skip blocks, mostly short
            skip_total = 0;
            skip_target = $urandom_range(500, 800);
            while (skip_total < skip_target)
            begin
                size = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                   : $urandom_range(0, 24);
                queue_block_header(cie_pkg::TypeSkip, 64'(size));
                for (int i = 0; i < size; i++)
                    queue_byte(8'($urandom));
                skip_total += size + 9;
            end

            case (closing)
                CLOSE_BAD_TYPE:
                begin
                    case ($urandom_range(0, 4))
                        0:       t = 8'h00;
                        1:       t = 8'h01;
                        2:       t = 8'h04;
                        3:       t = 8'hFF;
                        default: t = 8'($urandom);
                    endcase
                    if (t == cie_pkg::TypeSkip || t == cie_pkg::TypeImage)
                        t = 8'hFF;
                    size_word = {$urandom, $urandom};
                    queue_block_header(t, size_word);
                end
                CLOSE_TOO_SHORT:
                    queue_block_header(cie_pkg::TypeImage,
                                       64'($urandom_range(0, cie_pkg::DurationLen - 1)));
                CLOSE_EMPTY:
                begin
                    queue_block_header(cie_pkg::TypeImage, 64'(cie_pkg::DurationLen));
                    for (int i = 0; i < cie_pkg::DurationLen; i++)
                        queue_byte(8'($urandom));
                end
                default:
                begin
                    size = $urandom_range(700, 1000);
                    queue_block_header(cie_pkg::TypeImage, 64'(size + cie_pkg::DurationLen));
                    for (int i = 0; i < cie_pkg::DurationLen; i++)
                        queue_byte(8'($urandom));
                    for (int i = 0; i < size; i++)
                        queue_byte(8'($urandom), i == size / 2);
                end
            endcase
        end

        // bytes after completion are ignored; they fill the run up to its full length
        // and, when the first result is also the final one, keep the input busy while it is held off
        if (stream_bytes.size() + 16 < TotalItems)
            pad = TotalItems - stream_bytes.size();
        else
            pad = 16;
        for (int i = 0; i < pad; i++)
            queue_byte(8'($urandom), i == pad - 1);

        wait (rst_n);
        while (stream_bytes.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cie_pkg.sv
hw/rtl/cie_parser.sv
hw/rtl/cie_out_stage.sv
hw/rtl/container_image_extractor_unit.sv
verif/tb_container_image_extractor_unit.sv
